@@ rtl/pfc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and letter/cell helper functions for the Playfair cipher block.
package pfc_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam int unsigned SQ_CELLS = 25;
  localparam int unsigned LETTERS  = 26;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_Z = 5'd25;
  localparam cell_t   LAST_CELL = 5'd24;
  localparam coord_t  LAST_COORD = 3'd4;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_KEY     = 3'd1;
  localparam logic [2:0] OP_FINISH  = 3'd2;
  localparam logic [2:0] OP_ENCRYPT = 3'd3;
  localparam logic [2:0] OP_DECRYPT = 3'd4;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;

  // Clamp codes above Z to Z, merge J into I.
  function automatic letter_t fold_letter(letter_t raw);
    letter_t v;
    v = (raw > LETTER_Z) ? LETTER_Z : raw;
    if (v == LETTER_J) begin
      v = LETTER_I;
    end
    return v;
  endfunction

  function automatic coord_t row_of(cell_t pos);
    coord_t r;
    priority if (pos >= 5'd20) begin
      r = 3'd4;
    end else if (pos >= 5'd15) begin
      r = 3'd3;
    end else if (pos >= 5'd10) begin
      r = 3'd2;
    end else if (pos >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic cell_t row_base(coord_t row);
    return {row[2:0], 2'b00} + {2'b00, row};
  endfunction

  function automatic coord_t col_of(cell_t pos);
    cell_t diff;
    diff = pos - row_base(row_of(pos));
    return diff[2:0];
  endfunction

  function automatic cell_t cell_of(coord_t row, coord_t col);
    return row_base(row) + {2'b00, col};
  endfunction

  // Move one step along a row or column, wrapping at the edge.
  function automatic coord_t wrap_step(coord_t v, logic back);
    coord_t r;
    if (back) begin
      r = (v == 3'd0) ? LAST_COORD : v - 3'd1;
    end else begin
      r = (v == LAST_COORD) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

@@ rtl/pfc_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
module pfc_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/playfair_digraph_cipher_top.sv @@
`timescale 1ns / 1ps
// Top level of the Playfair cipher block: key square build and pair transform.
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------
//  command   start, busy        opcode, first_letter, second_letter
//  result    done (1 cycle)     out_first, out_second, status
//
// Clear, key letter, refused pair and unused opcodes are handled in the idle
// state; the result strobes the cycle after the transaction. A pair reads the
// position memory, then the key square memory, then registers the result.
// Finish walks the alphabet one letter a cycle. Reset clears the placed flags,
// fill count and ready flag; memory contents are only used after finish has
// filled every key square cell.
// The receiver cannot stall: a result is valid for the single done cycle.
module playfair_digraph_cipher_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode,
  input  logic [4:0] first_letter,
  input  logic [4:0] second_letter,
  output logic       done,
  output logic [4:0] out_first,
  output logic [4:0] out_second,
  output logic [1:0] status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_POS  = 2'd2;
  localparam logic [1:0] ST_SQ   = 2'd3;

  logic [1:0] state, state_next;
  logic [25:0] placed, placed_next;
  logic [4:0] fill_count, fill_count_next;
  logic square_ready, square_ready_next;
  logic [4:0] letter_cnt, letter_cnt_next;
  logic decrypt, decrypt_next;

  logic done_next;
  logic [4:0] out_first_next, out_second_next;
  logic [1:0] status_next;

  pfc_pkg::letter_t a_in, b_in;
  pfc_pkg::letter_t wr_letter;
  logic wr_en;

  // Position memory: cell of each placed letter. Key square: letter of each cell.
  pfc_pkg::cell_t pos_a, pos_b;
  pfc_pkg::letter_t sq_a, sq_b;
  pfc_pkg::cell_t sq_raddr_a, sq_raddr_b;

  pfc_pkg::coord_t ra, ca, rb, cb;

  assign a_in = pfc_pkg::fold_letter(first_letter);
  assign b_in = pfc_pkg::fold_letter(second_letter);
  assign busy = (state != ST_IDLE);

  // Placement writes both memories at once: square[fill] = letter, pos[letter] = fill.
  pfc_ram #(.WIDTH(5), .DEPTH(pfc_pkg::LETTERS)) u_pos_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_letter),
    .wdata   (fill_count),
    .raddr_a (a_in),
    .raddr_b (b_in),
    .rdata_a (pos_a),
    .rdata_b (pos_b)
  );

  pfc_ram #(.WIDTH(5), .DEPTH(pfc_pkg::SQ_CELLS)) u_sq_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (fill_count),
    .wdata   (wr_letter),
    .raddr_a (sq_raddr_a),
    .raddr_b (sq_raddr_b),
    .rdata_a (sq_a),
    .rdata_b (sq_b)
  );

  // Split positions into row and column and apply the three Playfair rules.
  always_comb begin
    ra = pfc_pkg::row_of(pos_a);
    ca = pfc_pkg::col_of(pos_a);
    rb = pfc_pkg::row_of(pos_b);
    cb = pfc_pkg::col_of(pos_b);
    if (ra == rb) begin
      sq_raddr_a = pfc_pkg::cell_of(ra, pfc_pkg::wrap_step(ca, decrypt));
      sq_raddr_b = pfc_pkg::cell_of(rb, pfc_pkg::wrap_step(cb, decrypt));
    end else if (ca == cb) begin
      sq_raddr_a = pfc_pkg::cell_of(pfc_pkg::wrap_step(ra, decrypt), ca);
      sq_raddr_b = pfc_pkg::cell_of(pfc_pkg::wrap_step(rb, decrypt), cb);
    end else begin
      sq_raddr_a = pfc_pkg::cell_of(ra, cb);
      sq_raddr_b = pfc_pkg::cell_of(rb, ca);
    end
  end

  always_comb begin
    state_next        = state;
    placed_next       = placed;
    fill_count_next   = fill_count;
    square_ready_next = square_ready;
    letter_cnt_next   = letter_cnt;
    decrypt_next      = decrypt;
    done_next         = 1'b0;
    out_first_next    = 5'd0;
    out_second_next   = 5'd0;
    status_next       = pfc_pkg::STAT_DONE;
    wr_en             = 1'b0;
    wr_letter         = a_in;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (opcode)
            pfc_pkg::OP_CLEAR: begin
              placed_next       = '0;
              fill_count_next   = 5'd0;
              square_ready_next = 1'b0;
              done_next         = 1'b1;
            end
            pfc_pkg::OP_KEY: begin
              done_next = 1'b1;
              if (placed[a_in]) begin
                status_next = pfc_pkg::STAT_IGNORED;
              end else if (fill_count <= pfc_pkg::LAST_CELL) begin
                wr_en               = 1'b1;
                placed_next[a_in]   = 1'b1;
                fill_count_next     = fill_count + 5'd1;
              end
            end
            pfc_pkg::OP_FINISH: begin
              letter_cnt_next = 5'd0;
              state_next      = ST_FILL;
            end
            pfc_pkg::OP_ENCRYPT, pfc_pkg::OP_DECRYPT: begin
              if (square_ready) begin
                // Position memory reads the folded letters this cycle.
                decrypt_next = (opcode == pfc_pkg::OP_DECRYPT);
                state_next   = ST_POS;
              end else begin
                done_next   = 1'b1;
                status_next = pfc_pkg::STAT_REFUSED;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        // Place the next unused letter, skipping J.
        wr_letter = letter_cnt;
        if (letter_cnt != pfc_pkg::LETTER_J && !placed[letter_cnt] &&
            fill_count <= pfc_pkg::LAST_CELL) begin
          wr_en                   = 1'b1;
          placed_next[letter_cnt] = 1'b1;
          fill_count_next         = fill_count + 5'd1;
        end
        if (letter_cnt == pfc_pkg::LETTER_Z) begin
          square_ready_next = 1'b1;
          done_next         = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          letter_cnt_next = letter_cnt + 5'd1;
        end
      end
      ST_POS: begin
        // Positions are back; the key square reads the target cells.
        state_next = ST_SQ;
      end
      ST_SQ: begin
        done_next       = 1'b1;
        out_first_next  = sq_a;
        out_second_next = sq_b;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      placed       <= '0;
      fill_count   <= 5'd0;
      square_ready <= 1'b0;
      letter_cnt   <= 5'd0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      placed       <= placed_next;
      fill_count   <= fill_count_next;
      square_ready <= square_ready_next;
      letter_cnt   <= letter_cnt_next;
      done         <= done_next;
    end
  end

  // Result payload and pair direction carry no reset.
  always_ff @(posedge clk) begin
    decrypt    <= decrypt_next;
    out_first  <= out_first_next;
    out_second <= out_second_next;
    status     <= status_next;
  end

endmodule
